// ----- rtl/nau_pkg.sv -----
`default_nettype none
package nau_pkg;

  // Operation class that the front end attaches to every item.
  typedef enum logic [2:0] {
    OP_SIGMOID,
    OP_RELU,
    OP_LEAKY,
    OP_SILU,
    OP_TANH,
    OP_GELU,
    OP_PASS
  } op_t;

  localparam int MODE_W      = 3;
  localparam int SLOPE_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE       = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEAK_SLOPE = 1'b1;

  localparam logic [MODE_W-1:0] MODE_SIGMOID = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RELU    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LEAKY   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SILU    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TANH    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_GELU    = 3'd5;
  // Unused codes; items pass through unchanged.
  localparam logic [MODE_W-1:0] MODE_RESERVED_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RESERVED_B = 3'd7;

  localparam logic [MODE_W-1:0]         MODE_RESET  = MODE_SIGMOID;
  localparam logic signed [SLOPE_W-1:0] SLOPE_RESET = 16'sd41;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Working width for rounding and range checks between registers.
  localparam int WIDE_W = 80;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // 0.044715 and sqrt(2/pi), both in Q30.
  localparam logic signed [26:0] GELU_CUBE  = 27'sd48012366;
  localparam logic signed [30:0] GELU_SCALE = 31'sd856722024;

  // Round half up while dropping n fraction bits.
  function automatic wide_t nau_rnd(input wide_t v, input int n);
    return (v + (wide_t'(1) <<< (n - 1))) >>> n;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/nau_front.sv -----
`default_nettype none
module nau_front #(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [DATA_WIDTH-1:0]         in_sample,
  input  wire logic                                 cfg_we,
  input  wire logic [nau_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [nau_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                      q_valid,
  input  wire logic                                 q_ready,
  output nau_pkg::op_t                              q_op,
  output logic signed [DATA_WIDTH-1:0]              q_x,
  output logic signed [nau_pkg::SLOPE_W-1:0]        q_slope
);
  import nau_pkg::*;

  logic [MODE_W-1:0]         mode_r;
  logic signed [SLOPE_W-1:0] slope_r;
  op_t                       op_c;

  op_t                         fifo_op_r    [QUEUE_DEPTH];
  logic signed [DATA_WIDTH-1:0] fifo_x_r    [QUEUE_DEPTH];
  logic signed [SLOPE_W-1:0]   fifo_slope_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]             count_r, count_nxt;
  logic                        push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RESET;
      slope_r <= SLOPE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_MODE) begin
        mode_r <= cfg_data[MODE_W-1:0];
      end else if (cfg_index == REG_LEAK_SLOPE) begin
        slope_r <= cfg_data[SLOPE_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (mode_r)
      MODE_SIGMOID: op_c = OP_SIGMOID;
      MODE_RELU:    op_c = OP_RELU;
      MODE_LEAKY:   op_c = OP_LEAKY;
      MODE_SILU:    op_c = OP_SILU;
      MODE_TANH:    op_c = OP_TANH;
      MODE_GELU:    op_c = OP_GELU;
      default:      op_c = OP_PASS;
    endcase
  end

  assign in_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  assign q_op    = fifo_op_r[rd_ptr_r];
  assign q_x     = fifo_x_r[rd_ptr_r];
  assign q_slope = fifo_slope_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_op_r[wr_ptr_r]    <= op_c;
      fifo_x_r[wr_ptr_r]     <= in_sample;
      fifo_slope_r[wr_ptr_r] <= slope_r;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/nau_div.sv -----
`default_nettype none
module nau_div #(
  parameter int NW  = 27,
  parameter int DW  = 14,
  parameter int QW  = 13,
  parameter int PLW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [NW-1:0]  num,
  input  wire logic [DW-1:0]  den,
  input  wire logic [PLW-1:0] in_pl,
  output logic                out_valid,
  output logic [QW-1:0]       quot,
  output logic [PLW-1:0]      out_pl
);
  localparam int CW = NW + DW + QW;

  // One quotient bit per stage, most significant first.
  logic [QW-1:0]  v_r;
  logic [NW-1:0]  rem_r  [QW];
  logic [DW-1:0]  den_r  [QW];
  logic [QW-1:0]  q_r    [QW];
  logic [PLW-1:0] pl_r   [QW];

  logic [QW-1:0]  v_in;
  logic [NW-1:0]  rem_in [QW];
  logic [DW-1:0]  den_in [QW];
  logic [QW-1:0]  q_in   [QW];
  logic [PLW-1:0] pl_in  [QW];

  logic [NW-1:0]  rem_nxt [QW];
  logic [QW-1:0]  q_nxt   [QW];

  assign v_in[0]   = in_valid;
  assign rem_in[0] = num;
  assign den_in[0] = den;
  assign q_in[0]   = '0;
  assign pl_in[0]  = in_pl;

  for (genvar s = 1; s < QW; s++) begin : g_link
    assign v_in[s]   = v_r[s-1];
    assign rem_in[s] = rem_r[s-1];
    assign den_in[s] = den_r[s-1];
    assign q_in[s]   = q_r[s-1];
    assign pl_in[s]  = pl_r[s-1];
  end

  always_comb begin
    logic [CW-1:0] trial;
    logic          take;
    for (int s = 0; s < QW; s++) begin
      trial      = CW'(den_in[s]) << (QW - 1 - s);
      take       = CW'(rem_in[s]) >= trial;
      rem_nxt[s] = take ? NW'(CW'(rem_in[s]) - trial) : rem_in[s];
      q_nxt[s]   = {q_in[s][QW-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QW; s++) begin
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= den_in[s];
        q_r[s]   <= q_nxt[s];
        pl_r[s]  <= pl_in[s];
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign quot      = q_r[QW-1];
  assign out_pl    = pl_r[QW-1];

endmodule
`default_nettype wire

// ----- rtl/nau_back.sv -----
`default_nettype none
module nau_back #(
  parameter int DATA_WIDTH     = 16,
  parameter int FRAC_BITS      = 12,
  parameter int TABLE_SEGMENTS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_valid,
  output logic                                   q_ready,
  input  wire nau_pkg::op_t                      q_op,
  input  wire logic signed [DATA_WIDTH-1:0]      q_x,
  input  wire logic signed [nau_pkg::SLOPE_W-1:0] q_slope,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [DATA_WIDTH-1:0]           out_activation,
  output logic                                   out_saturated
);
  import nau_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int KIW  = $clog2(TABLE_SEGMENTS + 1);
  localparam int MW   = F + 4;
  localparam int PW   = F + 5;
  localparam int KW   = F + 1;
  localparam int RMW  = F + 2;
  localparam int NW   = 2 * F + 3;
  localparam int QW   = F + 1;
  localparam int TW   = F + 2;
  localparam int XXW  = 2 * W;
  localparam int LPW  = W + SLOPE_W;
  localparam int LKW  = W + 17;
  localparam int X2W  = 33;
  localparam int X3PW = X2W + W;
  localparam int X3W  = 34;
  localparam int CPW  = X3W + 27;
  localparam int VW   = 34;
  localparam int SPW  = VW + 31;
  localparam int JFW  = F + 3;
  localparam int JPW  = W + JFW;
  localparam int PLW  = W + 3 + LKW + 3 + KW;

  localparam wide_t FX_ONE = wide_t'(1) <<< F;
  localparam wide_t SAT_HI = (wide_t'(1) <<< (W - 1)) - 1;
  localparam wide_t SAT_LO = -(wide_t'(1) <<< (W - 1));

  localparam longint Q30_ONE = longint'(1) <<< 30;

  // tanh knots and knot positions for arguments with F and F+1 fraction bits.
  logic [KW-1:0] knot_tab [TABLE_SEGMENTS+1];
  logic [PW-1:0] plo_tab  [TABLE_SEGMENTS+1];
  logic [PW-1:0] phi_tab  [TABLE_SEGMENTS+1];

  for (genvar gk = 0; gk <= TABLE_SEGMENTS; gk++) begin : g_tab
    localparam longint A_ARG = (longint'(gk) <<< 34) / TABLE_SEGMENTS;
    localparam longint P_LO  = (longint'(gk) <<< (FRAC_BITS + 3)) / TABLE_SEGMENTS;
    localparam longint P_HI  = (longint'(gk) <<< (FRAC_BITS + 4)) / TABLE_SEGMENTS;
    // exp(-2x) by a short series on 2x/256, then squared eight times.
    localparam longint S_ARG = A_ARG >>> 8;
    localparam longint R4    = Q30_ONE - S_ARG / 4;
    localparam longint R3    = Q30_ONE - ((S_ARG * R4) >>> 30) / 3;
    localparam longint R2    = Q30_ONE - ((S_ARG * R3) >>> 30) / 2;
    localparam longint R1    = Q30_ONE - ((S_ARG * R2) >>> 30);
    localparam longint E1    = (R1 * R1) >>> 30;
    localparam longint E2    = (E1 * E1) >>> 30;
    localparam longint E3    = (E2 * E2) >>> 30;
    localparam longint E4    = (E3 * E3) >>> 30;
    localparam longint E5    = (E4 * E4) >>> 30;
    localparam longint E6    = (E5 * E5) >>> 30;
    localparam longint E7    = (E6 * E6) >>> 30;
    localparam longint E8    = (E7 * E7) >>> 30;
    localparam longint T_Q30 = ((Q30_ONE - E8) <<< 30) / (Q30_ONE + E8);
    localparam longint KNOT  = (T_Q30 + (longint'(1) <<< (29 - FRAC_BITS)))
                               >>> (30 - FRAC_BITS);
    assign knot_tab[gk] = KW'(KNOT);
    assign plo_tab[gk]  = PW'(P_LO);
    assign phi_tab[gk]  = PW'(P_HI);
  end

  logic adv;
  assign adv     = !out_valid || out_ready;
  assign q_ready = adv;

  // Stage A: square and leak product.
  logic                  a_v_r;
  op_t                   a_op_r;
  logic signed [W-1:0]   a_x_r;
  logic signed [XXW-1:0] a_xx_r, a_xx_nxt;
  logic signed [LPW-1:0] a_lp_r, a_lp_nxt;

  always_comb begin
    a_xx_nxt = XXW'(q_x) * XXW'(q_x);
    a_lp_nxt = LPW'(q_slope) * LPW'(q_x);
  end

  // Stage B: x^3 product and leaky relu result.
  logic                   b_v_r;
  op_t                    b_op_r;
  logic signed [W-1:0]    b_x_r;
  logic signed [X3PW-1:0] b_x3p_r, b_x3p_nxt;
  logic signed [LKW-1:0]  b_lk_r, b_lk_nxt;

  always_comb begin
    wide_t              x2w;
    wide_t              lpw;
    logic signed [X2W-1:0] x2c;
    x2w = nau_rnd(wide_t'(a_xx_r), F);
    if (x2w > (wide_t'(1) <<< 31)) begin
      x2w = wide_t'(1) <<< 31;
    end
    x2c       = X2W'(x2w);
    b_x3p_nxt = X3PW'(x2c) * X3PW'(a_x_r);
    lpw       = nau_rnd(wide_t'(a_lp_r), F);
    b_lk_nxt  = (lpw > wide_t'(a_x_r)) ? LKW'(lpw) : LKW'(a_x_r);
  end

  // Stage C: cubic term times 0.044715.
  logic                  c_v_r;
  op_t                   c_op_r;
  logic signed [W-1:0]   c_x_r;
  logic signed [LKW-1:0] c_lk_r;
  logic signed [CPW-1:0] c_cp_r, c_cp_nxt;

  always_comb begin
    wide_t                 x3w;
    logic signed [X3W-1:0] x3c;
    x3w = nau_rnd(wide_t'(b_x3p_r), F);
    if (x3w > (wide_t'(1) <<< 32)) begin
      x3w = wide_t'(1) <<< 32;
    end else if (x3w < -(wide_t'(1) <<< 32)) begin
      x3w = -(wide_t'(1) <<< 32);
    end
    x3c      = X3W'(x3w);
    c_cp_nxt = CPW'(x3c) * CPW'(GELU_CUBE);
  end

  // Stage D: scale by sqrt(2/pi).
  logic                  d_v_r;
  op_t                   d_op_r;
  logic signed [W-1:0]   d_x_r;
  logic signed [LKW-1:0] d_lk_r;
  logic signed [SPW-1:0] d_sp_r, d_sp_nxt;

  always_comb begin
    logic signed [VW-1:0] vc;
    vc       = VW'(wide_t'(c_x_r) + nau_rnd(wide_t'(c_cp_r), 30));
    d_sp_nxt = SPW'(vc) * SPW'(GELU_SCALE);
  end

  // Stage E: tanh argument, sign and magnitude.
  logic                  e_v_r;
  op_t                   e_op_r;
  logic signed [W-1:0]   e_x_r;
  logic signed [LKW-1:0] e_lk_r;
  logic                  e_neg_r, e_neg_nxt;
  logic                  e_big_r, e_big_nxt;
  logic                  e_g_r, e_g_nxt;
  logic [MW-1:0]         e_m_r, e_m_nxt;

  always_comb begin
    wide_t uw;
    wide_t mag;
    wide_t span;
    uw = (d_op_r == OP_GELU) ? nau_rnd(wide_t'(d_sp_r), 30) : wide_t'(d_x_r);
    // The sigmoid reads x with one more fraction bit, which halves it.
    e_g_nxt   = (d_op_r == OP_SIGMOID) || (d_op_r == OP_SILU);
    e_neg_nxt = uw < 0;
    mag       = e_neg_nxt ? -uw : uw;
    span      = e_g_nxt ? (wide_t'(1) <<< (F + 4)) : (wide_t'(1) <<< (F + 3));
    e_big_nxt = mag >= span;
    e_m_nxt   = e_big_nxt ? '0 : mag[MW-1:0];
  end

  // Stage F: segment index.
  logic                  f_v_r;
  op_t                   f_op_r;
  logic signed [W-1:0]   f_x_r;
  logic signed [LKW-1:0] f_lk_r;
  logic                  f_neg_r, f_big_r, f_g_r;
  logic [MW-1:0]         f_m_r;
  logic [KIW-1:0]        f_k_r, f_k_nxt;

  always_comb begin
    wide_t kw;
    kw      = e_g_r ? ((wide_t'(e_m_r) * TABLE_SEGMENTS) >>> (F + 4))
                    : ((wide_t'(e_m_r) * TABLE_SEGMENTS) >>> (F + 3));
    f_k_nxt = kw[KIW-1:0];
  end

  // Stage G: table reads.
  logic                  g_v_r;
  op_t                   g_op_r;
  logic signed [W-1:0]   g_x_r;
  logic signed [LKW-1:0] g_lk_r;
  logic                  g_neg_r, g_big_r;
  logic [KW-1:0]         g_y0_r, g_y0_nxt;
  logic [KW-1:0]         g_num_r, g_num_nxt;
  logic [RMW-1:0]        g_rem_r, g_rem_nxt;
  logic [RMW-1:0]        g_den_r, g_den_nxt;
  logic                  g_zd_r, g_zd_nxt;

  always_comb begin
    logic [KIW-1:0] kp1;
    logic [KW-1:0]  y1;
    logic [PW-1:0]  p0;
    logic [PW-1:0]  p1;
    kp1       = f_k_r + KIW'(1);
    g_y0_nxt  = knot_tab[f_k_r];
    y1        = knot_tab[kp1];
    p0        = f_g_r ? phi_tab[f_k_r] : plo_tab[f_k_r];
    p1        = f_g_r ? phi_tab[kp1] : plo_tab[kp1];
    g_num_nxt = y1 - g_y0_nxt;
    g_rem_nxt = RMW'(PW'(f_m_r) - p0);
    g_den_nxt = RMW'(p1 - p0);
    g_zd_nxt  = (p1 == p0);
  end

  // Stage H: interpolation numerator.
  logic                  h_v_r;
  logic [PLW-1:0]        h_pl_r;
  logic [NW-1:0]         h_n_r, h_n_nxt;
  logic [RMW-1:0]        h_den_r;

  assign h_n_nxt = NW'(g_num_r) * NW'(g_rem_r);

  logic           dv_valid;
  logic [QW-1:0]  dv_q;
  logic [PLW-1:0] dv_pl;

  nau_div #(
    .NW  (NW),
    .DW  (RMW),
    .QW  (QW),
    .PLW (PLW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (h_v_r),
    .num       (h_n_r),
    .den       (h_den_r),
    .in_pl     (h_pl_r),
    .out_valid (dv_valid),
    .quot      (dv_q),
    .out_pl    (dv_pl)
  );

  logic signed [W-1:0]   dv_x;
  op_t                   dv_op;
  logic signed [LKW-1:0] dv_lk;
  logic                  dv_neg, dv_big, dv_zd;
  logic [KW-1:0]         dv_y0;

  assign {dv_x, dv_op, dv_lk, dv_neg, dv_big, dv_zd, dv_y0} = dv_pl;

  // Stage I: signed tanh value.
  logic                  i_v_r;
  op_t                   i_op_r;
  logic signed [W-1:0]   i_x_r;
  logic signed [LKW-1:0] i_lk_r;
  logic signed [TW-1:0]  i_t_r, i_t_nxt;

  always_comb begin
    wide_t yw;
    yw = dv_zd ? wide_t'(dv_y0) : wide_t'(dv_y0) + wide_t'(dv_q);
    if (dv_big) begin
      yw = FX_ONE;
    end
    i_t_nxt = dv_neg ? TW'(-yw) : TW'(yw);
  end

  // Stage J: sigmoid and the final product for silu and gelu.
  logic                  j_v_r;
  op_t                   j_op_r;
  logic signed [W-1:0]   j_x_r;
  logic signed [LKW-1:0] j_lk_r;
  logic signed [TW-1:0]  j_t_r;
  logic signed [TW-1:0]  j_sig_r, j_sig_nxt;
  logic signed [JPW-1:0] j_prod_r, j_prod_nxt;

  always_comb begin
    wide_t                 sigw;
    wide_t                 fw;
    logic signed [JFW-1:0] fc;
    sigw       = (FX_ONE + wide_t'(i_t_r) + wide_t'(1)) >>> 1;
    fw         = (i_op_r == OP_GELU) ? FX_ONE + wide_t'(i_t_r) : sigw;
    fc         = JFW'(fw);
    j_sig_nxt  = TW'(sigw);
    j_prod_nxt = JPW'(i_x_r) * JPW'(fc);
  end

  // Stage K: selection and saturation into the output register.
  logic                out_valid_r;
  logic signed [W-1:0] out_activation_r, out_activation_nxt;
  logic                out_saturated_r, out_saturated_nxt;

  always_comb begin
    wide_t rw;
    case (j_op_r)
      OP_SIGMOID: rw = wide_t'(j_sig_r);
      OP_RELU:    rw = (j_x_r < 0) ? '0 : wide_t'(j_x_r);
      OP_LEAKY:   rw = wide_t'(j_lk_r);
      OP_SILU:    rw = nau_rnd(wide_t'(j_prod_r), F);
      OP_TANH:    rw = wide_t'(j_t_r);
      OP_GELU:    rw = nau_rnd(wide_t'(j_prod_r), F + 1);
      default:    rw = wide_t'(j_x_r);
    endcase
    out_saturated_nxt = 1'b0;
    if (rw > SAT_HI) begin
      rw                = SAT_HI;
      out_saturated_nxt = 1'b1;
    end else if (rw < SAT_LO) begin
      rw                = SAT_LO;
      out_saturated_nxt = 1'b1;
    end
    out_activation_nxt = W'(rw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      d_v_r       <= 1'b0;
      e_v_r       <= 1'b0;
      f_v_r       <= 1'b0;
      g_v_r       <= 1'b0;
      h_v_r       <= 1'b0;
      i_v_r       <= 1'b0;
      j_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_v_r       <= q_valid;
      b_v_r       <= a_v_r;
      c_v_r       <= b_v_r;
      d_v_r       <= c_v_r;
      e_v_r       <= d_v_r;
      f_v_r       <= e_v_r;
      g_v_r       <= f_v_r;
      h_v_r       <= g_v_r;
      i_v_r       <= dv_valid;
      j_v_r       <= i_v_r;
      out_valid_r <= j_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r  <= q_op;
      a_x_r   <= q_x;
      a_xx_r  <= a_xx_nxt;
      a_lp_r  <= a_lp_nxt;

      b_op_r  <= a_op_r;
      b_x_r   <= a_x_r;
      b_x3p_r <= b_x3p_nxt;
      b_lk_r  <= b_lk_nxt;

      c_op_r  <= b_op_r;
      c_x_r   <= b_x_r;
      c_lk_r  <= b_lk_r;
      c_cp_r  <= c_cp_nxt;

      d_op_r  <= c_op_r;
      d_x_r   <= c_x_r;
      d_lk_r  <= c_lk_r;
      d_sp_r  <= d_sp_nxt;

      e_op_r  <= d_op_r;
      e_x_r   <= d_x_r;
      e_lk_r  <= d_lk_r;
      e_neg_r <= e_neg_nxt;
      e_big_r <= e_big_nxt;
      e_g_r   <= e_g_nxt;
      e_m_r   <= e_m_nxt;

      f_op_r  <= e_op_r;
      f_x_r   <= e_x_r;
      f_lk_r  <= e_lk_r;
      f_neg_r <= e_neg_r;
      f_big_r <= e_big_r;
      f_g_r   <= e_g_r;
      f_m_r   <= e_m_r;
      f_k_r   <= f_k_nxt;

      g_op_r  <= f_op_r;
      g_x_r   <= f_x_r;
      g_lk_r  <= f_lk_r;
      g_neg_r <= f_neg_r;
      g_big_r <= f_big_r;
      g_y0_r  <= g_y0_nxt;
      g_num_r <= g_num_nxt;
      g_rem_r <= g_rem_nxt;
      g_den_r <= g_den_nxt;
      g_zd_r  <= g_zd_nxt;

      h_n_r   <= h_n_nxt;
      h_den_r <= g_den_r;
      h_pl_r  <= {g_x_r, g_op_r, g_lk_r, g_neg_r, g_big_r, g_zd_r, g_y0_r};

      i_op_r  <= dv_op;
      i_x_r   <= dv_x;
      i_lk_r  <= dv_lk;
      i_t_r   <= i_t_nxt;

      j_op_r   <= i_op_r;
      j_x_r    <= i_x_r;
      j_lk_r   <= i_lk_r;
      j_t_r    <= i_t_r;
      j_sig_r  <= j_sig_nxt;
      j_prod_r <= j_prod_nxt;

      out_activation_r <= out_activation_nxt;
      out_saturated_r  <= out_saturated_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_activation = out_activation_r;
  assign out_saturated  = out_saturated_r;

endmodule
`default_nettype wire

// ----- rtl/neural_activation_unit.sv -----
`default_nettype none
// Channel   Ports                                          Direction
// input     in_valid, in_ready, in_sample                  item in
// result    out_valid, out_ready, out_activation,          item out
//           out_saturated
// config    cfg_we, cfg_index, cfg_data                    register write
//
// One item per cycle is accepted while in_ready is high, and one result per cycle
// is delivered while out_ready is high. Results pass through the back-end pipeline
// and the one-bit-per-stage interpolation divider.
// A four-entry queue sits between the front end and the back end; a stalled
// result holds the whole back-end pipeline, and in_ready drops once the queue fills.
// Synchronous reset empties the queue and the pipeline; no clearing pass follows.
module neural_activation_unit #(
  parameter int DATA_WIDTH     = 16,
  parameter int FRAC_BITS      = 12,
  parameter int TABLE_SEGMENTS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [DATA_WIDTH-1:0]    in_sample,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [DATA_WIDTH-1:0]         out_activation,
  output logic                                 out_saturated,
  input  wire logic                            cfg_we,
  input  wire logic [nau_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [nau_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nau_pkg::*;

  logic                         q_valid;
  logic                         q_ready;
  op_t                          q_op;
  logic signed [DATA_WIDTH-1:0] q_x;
  logic signed [SLOPE_W-1:0]    q_slope;

  nau_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_op      (q_op),
    .q_x       (q_x),
    .q_slope   (q_slope)
  );

  nau_back #(
    .DATA_WIDTH     (DATA_WIDTH),
    .FRAC_BITS      (FRAC_BITS),
    .TABLE_SEGMENTS (TABLE_SEGMENTS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_op           (q_op),
    .q_x            (q_x),
    .q_slope        (q_slope),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_activation (out_activation),
    .out_saturated  (out_saturated)
  );

endmodule
`default_nettype wire

// ----- rtl/nau_checker.sv -----
`default_nettype none
module nau_checker #(
  parameter int DATA_WIDTH = 16
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic signed [DATA_WIDTH-1:0] out_activation,
  input wire logic                         out_saturated
);
  localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // A result waiting for the consumer holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_activation)
                               && $stable(out_saturated))
    else $error("result changed while stalled");

  // A clipped result sits on one end of the range.
  a_sat_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_activation == MAX_VAL
                                   || out_activation == MIN_VAL)
    else $error("saturated result not at a range end");

  // Reset empties the pipeline.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Reset empties the queue, so the input side is open.
  a_rst_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind neural_activation_unit nau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_nau_checker (.*);
`default_nettype wire

// ----- dv/tb_neural_activation_unit.sv -----
`timescale 1ns / 100ps

typedef struct {
  logic signed [15:0] activation;
  logic               saturated;
} act_result_t;

class activation_scoreboard;
  logic [2:0]         mode;
  logic signed [15:0] slope;
  longint             tanh_knots[0:64];
  act_result_t        pending_q[$];
  int                 mismatches;
  int                 checked;

  function new();
    longint a, s, r;
    mode = nau_pkg::MODE_RESET;
    slope = nau_pkg::SLOPE_RESET;
    mismatches = 0;
    checked = 0;
    for (int k = 0; k <= 64; k++) begin
      a = (longint'(k) <<< 34) / 64;
      s = a >>> 8;
      r = (64'sd1 <<< 30) - s / 4;
      r = (64'sd1 <<< 30) - ((s * r) >>> 30) / 3;
      r = (64'sd1 <<< 30) - ((s * r) >>> 30) / 2;
      r = (64'sd1 <<< 30) - ((s * r) >>> 30);
      for (int i = 0; i < 8; i++) r = (r * r) >>> 30;
      a = (((64'sd1 <<< 30) - r) <<< 30) / ((64'sd1 <<< 30) + r);
      tanh_knots[k] = (a + (64'sd1 <<< 17)) >>> 18;
    end
  endfunction

  // Half-up rounding that drops n fraction bits.
  function longint round_drop(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // Table tanh of u with g fraction bits, result in Q4.12.
  function longint tanh_fx(longint u, int g);
    longint span, m, y, k, p0, p1;
    span = 64'sd8 <<< g;
    m = (u < 0) ? -u : u;
    if (m >= span) begin
      y = 4096;
    end else begin
      k = (m * 64) / span;
      p0 = (k * span) / 64;
      p1 = ((k + 1) * span) / 64;
      if (p1 > p0)
        y = tanh_knots[k]
            + ((tanh_knots[k+1] - tanh_knots[k]) * (m - p0)) / (p1 - p0);
      else y = tanh_knots[k];
    end
    return (u < 0) ? -y : y;
  endfunction

  function longint sigmoid_fx(longint x);
    return round_drop(4096 + tanh_fx(x, 13), 1);
  endfunction

  function longint gelu_fx(longint x);
    longint x2, x3, v, u;
    x2 = round_drop(x * x, 12);
    if (x2 > (64'sd1 <<< 31)) x2 = 64'sd1 <<< 31;
    x3 = round_drop(x2 * x, 12);
    if (x3 > (64'sd1 <<< 32)) x3 = 64'sd1 <<< 32;
    if (x3 < -(64'sd1 <<< 32)) x3 = -(64'sd1 <<< 32);
    v = x + round_drop(x3 * 64'sd48012366, 30);
    u = round_drop(v * 64'sd856722024, 30);
    return round_drop(x * (4096 + tanh_fx(u, 12)), 13);
  endfunction

  function void note_input(logic signed [15:0] sample);
    longint x, r, t;
    act_result_t e;
    x = sample;
    case (mode)
      nau_pkg::MODE_SIGMOID: r = sigmoid_fx(x);
      nau_pkg::MODE_RELU:    r = (x < 0) ? 0 : x;
      nau_pkg::MODE_LEAKY: begin
        t = round_drop(longint'(slope) * x, 12);
        r = (t > x) ? t : x;
      end
      nau_pkg::MODE_SILU:    r = round_drop(x * sigmoid_fx(x), 12);
      nau_pkg::MODE_TANH:    r = tanh_fx(x, 12);
      nau_pkg::MODE_GELU:    r = gelu_fx(x);
      default:               r = x;
    endcase
    e.saturated = 1'b0;
    if (r > 32767) begin
      r = 32767;
      e.saturated = 1'b1;
    end else if (r < -32768) begin
      r = -32768;
      e.saturated = 1'b1;
    end
    e.activation = r[15:0];
    pending_q.push_back(e);
  endfunction

  function void check_result(logic signed [15:0] act, logic sat);
    act_result_t e;
    checked++;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: result %0d with no item waiting", act);
      return;
    end
    e = pending_q.pop_front();
    if (act !== e.activation || sat !== e.saturated) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: mode %0d: expected %0d sat %0b, got %0d sat %0b",
                 mode, e.activation, e.saturated, act, sat);
    end
  endfunction
endclass

module tb_neural_activation_unit;
  import nau_pkg::*;

  localparam int LATENCY = 24;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_activation;
  logic out_saturated;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic hold_req = 1'b0;
  logic calm = 1'b0;
  int items_sent = 0;
  activation_scoreboard sb = new();

  neural_activation_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_activation(out_activation), .out_saturated(out_saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_MODE) sb.mode = value[2:0];
    else sb.slope = value;
  endtask

  // Called at a falling edge and returns at one, so items can follow
  // back to back. Acceptance is decided from the stable values just
  // before the next rising edge.
  task automatic send_item(logic signed [15:0] value);
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = value;
    forever begin
      #1;
      if (in_ready) break;
      @(negedge clk);
    end
    @(posedge clk);
    sb.note_input(value);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 8192)) - 16'sd4096;
      1: return 16'($urandom_range(0, 32767));
      2: return -$signed({1'b0, 15'($urandom_range(0, 32767))}) - 1;
      3: return ($urandom_range(0, 1)) ? 16'sh7fff - 16'($urandom_range(0, 3))
                                        : -16'sh8000 + 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  always begin
    @(negedge clk);
    if (hold_req) begin
      out_ready = 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
    end
    out_ready = calm || ($urandom_range(0, 99) >= 17);
    #1;
    if (rst_n && out_valid && out_ready) begin
      logic signed [15:0] act;
      logic sat;
      act = out_activation;
      sat = out_saturated;
      @(posedge clk);
      sb.check_result(act, sat);
    end
  end

  initial begin
    logic [2:0] modes[12];
    logic [15:0] slopes[12];
    logic signed [15:0] directed[12];
    modes = '{MODE_SIGMOID, MODE_RELU, MODE_LEAKY, MODE_LEAKY, MODE_LEAKY, MODE_LEAKY,
              MODE_SILU, MODE_TANH, MODE_GELU, MODE_RESERVED_A, MODE_RESERVED_B,
              MODE_LEAKY};
    slopes = '{16'd41, 16'h8000, 16'd41, 16'h8000, 16'h7fff, 16'hf000,
               16'd0, 16'h1234, 16'h1000, 16'hffff, 16'h0001, 16'($urandom)};
    directed = '{16'sh7fff, -16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd4096, -16'sd4096,
                 16'sd512, -16'sd513, 16'sh4000, -16'sh4001, 16'sh5555};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int p = 0; p < 12; p++) begin
      write_reg(REG_MODE, {13'd0, modes[p]});
      write_reg(REG_LEAK_SLOPE, slopes[p]);
      calm = (p == 4);
      foreach (directed[i]) send_item(directed[i]);
      if (p == 2) hold_req = 1'b1;
      repeat (38) send_item(pick_sample());
      // Hold the sender back until the block has emptied before reconfiguring.
      drain();
    end
    calm = 1'b0;
    $display("Sent %0d samples over 12 register settings covering all modes,", items_sent);
    $display("slope extremes and pass-through codes; %0d results checked.", sb.checked);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule
